// File: src/rtks_pkg.sv
package rtks_pkg;

    // Fixed geometry of the tree.
    localparam int unsigned ROOT_ENTRIES    = 256;
    localparam int unsigned INTERIOR_FANOUT = 8192;
    localparam int unsigned LEAF_FANOUT     = 4096;
    localparam int unsigned KEY_W           = 13;
    localparam int unsigned BIT_W           = 12;
    localparam int unsigned LEVEL_W         = 3;

    // Walk levels: root, minor slot, then four inode slices.
    localparam logic [LEVEL_W-1:0] LVL_ROOT  = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_MINOR = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_INO0  = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_INO1  = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_INO2  = 3'd4;
    localparam logic [LEVEL_W-1:0] LVL_LAST  = 3'd5;

    // Command and status codes.
    localparam logic CMD_QUERY   = 1'b0;
    localparam logic CMD_INSERT  = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  dev_major;
        logic [7:0]  dev_minor;
        logic [63:0] inode_number;
    } t_req;

    typedef struct packed {
        logic was_present;
        logic inserted;
        logic status;
    } t_rsp;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK,
        S_LEAF,
        S_ALLOC
    } t_state;

    // Slot index used inside the node that is visited at a given level.
    function automatic logic [KEY_W-1:0] level_key(input t_req req,
                                                   input logic [LEVEL_W-1:0] level);
        logic [KEY_W-1:0] key;
        case (level)
            LVL_ROOT:  key = {5'd0, req.dev_major};
            LVL_MINOR: key = {5'd0, req.dev_minor};
            LVL_INO0:  key = req.inode_number[63:51];
            LVL_INO1:  key = req.inode_number[50:38];
            LVL_INO2:  key = req.inode_number[37:25];
            LVL_LAST:  key = req.inode_number[24:12];
            default:   key = '0;
        endcase
        return key;
    endfunction

    // Bit picked inside a leaf bitmap.
    function automatic logic [BIT_W-1:0] leaf_key(input t_req req);
        return req.inode_number[BIT_W-1:0];
    endfunction

endpackage

// File: src/rtks_ram.sv
module rtks_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 2
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                        i_wdata,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single port, read data registered; a write returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/radix_trie_key_set.sv
// Channel   Direction  Ports                Handshake
// request   in         start, busy, i_req   taken when start is high and busy is low
// result    out        o_done, o_rsp        valid for the one cycle o_done is high
//
// A request runs from the edge that accepts it to the edge that
// takes its result; the next request can be accepted at that same edge.
// The walk reads the interior memory once per tree level (root plus five
// levels); a hit then reads the leaf, and an insert that misses writes
// one level per cycle for each node or leaf it creates.
// After reset a clearing pass sweeps both memories, one entry per cycle,
// with busy high.
// One request is in flight at a time; results cannot be stalled.
module radix_trie_key_set
    import rtks_pkg::*;
#(
    parameter int unsigned INTERIOR_NODES = 16,
    parameter int unsigned LEAF_NODES     = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    // Node 0 of the interior memory is the root; pointer p selects node p, or leaf p-1 at the last level.
    localparam int unsigned NW     = $clog2(INTERIOR_NODES + 1);
    localparam int unsigned PMAX   = (INTERIOR_NODES > LEAF_NODES) ?
                                     INTERIOR_NODES : LEAF_NODES;
    localparam int unsigned PW     = $clog2(PMAX + 1);
    localparam int unsigned LUW    = $clog2(LEAF_NODES + 1);
    localparam int unsigned IDEPTH = (INTERIOR_NODES + 1) * INTERIOR_FANOUT;
    localparam int unsigned LDEPTH = LEAF_NODES * LEAF_FANOUT;
    localparam int unsigned IAW    = NW + KEY_W;
    localparam int unsigned LAW    = $clog2(LDEPTH);
    localparam int unsigned CAW    = (IAW > LAW) ? IAW : LAW;
    localparam int unsigned CDEPTH = (IDEPTH > LDEPTH) ? IDEPTH : LDEPTH;
    localparam int unsigned UW     = NW + LEVEL_W;

    t_state               r_state, n_state;
    t_req                 r_req, n_req;
    t_rsp                 r_rsp, n_rsp;
    logic                 r_done, n_done;
    logic [LEVEL_W-1:0]   r_level, n_level;
    logic [NW-1:0]        r_node, n_node;
    logic [PW-1:0]        r_leaf_idx, n_leaf_idx;
    logic [NW-1:0]        r_int_used, n_int_used;
    logic [LUW-1:0]       r_leaf_used, n_leaf_used;
    logic [CAW-1:0]       r_clr, n_clr;

    logic                 int_we;
    logic [IAW-1:0]       int_addr;
    logic [PW-1:0]        int_wdata;
    logic [PW-1:0]        int_rdata;
    logic                 leaf_we;
    logic [LAW-1:0]       leaf_addr;
    logic                 leaf_wdata;
    logic                 leaf_rdata;

    logic                 ptr_zero;
    logic                 pool_ok;
    logic [LEVEL_W-1:0]   need_int;
    logic                 clr_last;
    logic                 is_insert;

    function automatic logic [LAW-1:0] leaf_address(input logic [PW-1:0] idx,
                                                    input logic [BIT_W-1:0] bitk);
        return LAW'(LAW'(idx) << BIT_W) + LAW'(bitk);
    endfunction

    rtks_ram #(
        .WIDTH (PW),
        .DEPTH (IDEPTH)
    ) u_interior (
        .i_clk   (i_clk),
        .i_we    (int_we),
        .i_addr  (int_addr),
        .i_wdata (int_wdata),
        .o_rdata (int_rdata)
    );

    rtks_ram #(
        .WIDTH (1),
        .DEPTH (LDEPTH)
    ) u_leaf (
        .i_clk   (i_clk),
        .i_we    (leaf_we),
        .i_addr  (leaf_addr),
        .i_wdata (leaf_wdata),
        .o_rdata (leaf_rdata)
    );

    // Status of the walk and of the node pools.
    assign ptr_zero  = (int_rdata == '0);
    assign need_int  = LVL_LAST - r_level;
    assign pool_ok   = ((UW'(r_int_used) + UW'(need_int)) <= UW'(INTERIOR_NODES)) &&
                       (r_leaf_used < LUW'(LEAF_NODES));
    assign clr_last  = (r_clr == CAW'(CDEPTH - 1));
    assign is_insert = (r_req.command == CMD_INSERT);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (!ptr_zero) begin
                    if (r_level == LVL_LAST) begin
                        n_state = S_LEAF;
                    end
                end else if (is_insert && pool_ok) begin
                    n_state = S_ALLOC;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_LEAF: begin
                n_state = S_IDLE;
            end
            S_ALLOC: begin
                if (r_level == LVL_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Memory accesses and register updates per state.
    always_comb begin
        n_req       = r_req;
        n_rsp       = r_rsp;
        n_done      = 1'b0;
        n_level     = r_level;
        n_node      = r_node;
        n_leaf_idx  = r_leaf_idx;
        n_int_used  = r_int_used;
        n_leaf_used = r_leaf_used;
        n_clr       = r_clr;
        int_we      = 1'b0;
        int_addr    = {r_node, level_key(r_req, r_level)};
        int_wdata   = '0;
        leaf_we     = 1'b0;
        leaf_addr   = leaf_address(r_leaf_idx, leaf_key(r_req));
        leaf_wdata  = 1'b0;
        case (r_state)
            S_CLEAR: begin
                // Zero one entry of each memory per cycle.
                n_clr     = r_clr + 1'b1;
                int_we    = ((CAW + 1)'(r_clr) < (CAW + 1)'(IDEPTH));
                int_addr  = IAW'(r_clr);
                leaf_we   = ((CAW + 1)'(r_clr) < (CAW + 1)'(LDEPTH));
                leaf_addr = LAW'(r_clr);
            end
            S_IDLE: begin
                // Read the root slot of the new request.
                if (start) begin
                    n_req    = i_req;
                    n_level  = LVL_ROOT;
                    n_node   = '0;
                    int_addr = {NW'(0), level_key(i_req, LVL_ROOT)};
                end
            end
            S_WALK: begin
                if (!ptr_zero) begin
                    if (r_level != LVL_LAST) begin
                        // Follow the pointer and read the next level at once.
                        n_level  = r_level + 1'b1;
                        n_node   = NW'(int_rdata);
                        int_addr = {NW'(int_rdata), level_key(r_req, r_level + 1'b1)};
                    end else begin
                        n_leaf_idx = int_rdata - 1'b1;
                        leaf_addr  = leaf_address(int_rdata - 1'b1, leaf_key(r_req));
                    end
                end else if (!(is_insert && pool_ok)) begin
                    // Key absent: a query ends here, as does an insert without room.
                    n_done = 1'b1;
                    n_rsp  = '{was_present: 1'b0, inserted: 1'b0,
                               status: is_insert ? STATUS_FULL : STATUS_OK};
                end
            end
            S_LEAF: begin
                n_done     = 1'b1;
                leaf_we    = is_insert && !leaf_rdata;
                leaf_wdata = 1'b1;
                n_rsp      = '{was_present: leaf_rdata,
                               inserted: is_insert && !leaf_rdata,
                               status: STATUS_OK};
            end
            S_ALLOC: begin
                // New nodes are empty, so the rest of the path is written blind.
                int_we = 1'b1;
                if (r_level != LVL_LAST) begin
                    int_wdata  = PW'(r_int_used) + 1'b1;
                    n_int_used = r_int_used + 1'b1;
                    n_node     = r_int_used + 1'b1;
                    n_level    = r_level + 1'b1;
                end else begin
                    int_wdata   = PW'(r_leaf_used) + 1'b1;
                    n_leaf_used = r_leaf_used + 1'b1;
                    leaf_we     = 1'b1;
                    leaf_wdata  = 1'b1;
                    leaf_addr   = leaf_address(PW'(r_leaf_used), leaf_key(r_req));
                    n_done      = 1'b1;
                    n_rsp       = '{was_present: 1'b0, inserted: 1'b1, status: STATUS_OK};
                end
            end
            default: begin
                n_done = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_done      <= 1'b0;
            r_int_used  <= '0;
            r_leaf_used <= '0;
            r_clr       <= '0;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_int_used  <= n_int_used;
            r_leaf_used <= n_leaf_used;
            r_clr       <= n_clr;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_rsp      <= n_rsp;
        r_level    <= n_level;
        r_node     <= n_node;
        r_leaf_idx <= n_leaf_idx;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    // A result appears only once the sequencer is back to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_state == S_IDLE))
        else $error("result strobe while sequencer active");

    // An accepted request keeps the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    // Insert outcome is consistent.
    a_insert_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.inserted) |-> (!o_rsp.was_present && o_rsp.status == STATUS_OK))
        else $error("inserted result with inconsistent flags");

    // Pools never overrun.
    a_pool_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (UW'(r_int_used) <= UW'(INTERIOR_NODES)) && (r_leaf_used <= LUW'(LEAF_NODES)))
        else $error("node pool count out of range");

endmodule
